// ===== src/mutex_with_wake_all_queue_defines.svh =====
// assertion macros for the mutex with wake-all queue
// used by the front and back modules, needs clk and rst_n in scope
`ifndef MUTEX_WITH_WAKE_ALL_QUEUE_DEFINES_SVH
`define MUTEX_WITH_WAKE_ALL_QUEUE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define MWQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mwq assertion failed");
// next-cycle implication, checked outside reset
`define MWQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mwq assertion failed");
`else
`define MWQ_ASSERT_IMP(lbl, ante, cons)
`define MWQ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/mwq_pkg.sv =====
// shared constants and types of the mutex with wake-all queue
// no dependencies
`default_nettype none

package mwq_pkg;

  localparam int WAIT_DEPTH_DEF   = 16;
  localparam int TASK_ID_BITS_DEF = 8;

  // depth of the command queue between front and back
  localparam int CQ_DEPTH = 2;

  localparam logic [1:0] MODE_ATTEMPT = 2'd0;
  localparam logic [1:0] MODE_LOCK    = 2'd1;
  localparam logic [1:0] MODE_UNLOCK  = 2'd2;
  localparam logic [1:0] MODE_INIT    = 2'd3;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // classified request, exactly one flag set
  typedef struct packed {
    logic is_try;
    logic is_lock;
    logic is_unlock;
    logic is_init;
  } mwq_op_t;

endpackage

`default_nettype wire

// ===== src/mwq_req_if.sv =====
// request channel: valid/ready with mode and task id
// depends on nothing
`default_nettype none

interface mwq_req_if #(
  parameter int TID_W = 8
) ();
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [TID_W-1:0] task_id;

  modport source (output valid, output mode, output task_id, input ready);
  modport sink   (input valid, input mode, input task_id, output ready);
endinterface

`default_nettype wire

// ===== src/mwq_rsp_if.sv =====
// result channel: valid/ready with status and release fields
// depends on nothing
`default_nettype none

interface mwq_rsp_if #(
  parameter int TID_W = 8
) ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic             success;
  logic             queue_full;
  logic             owner_valid;
  logic [TID_W-1:0] owner_task;
  logic             requester_holds;
  logic [TID_W-1:0] released_task;
  logic             last;

  modport source (output valid, output kind, output success, output queue_full,
                  output owner_valid, output owner_task, output requester_holds,
                  output released_task, output last, input ready);
  modport sink   (input valid, input kind, input success, input queue_full,
                  input owner_valid, input owner_task, input requester_holds,
                  input released_task, input last, output ready);
endinterface

`default_nettype wire

// ===== src/mwq_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mwq_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/mwq_front.sv =====
// front: accepts requests, decodes the mode, buffers them in a two-entry queue
// depends on mwq_pkg, mwq_req_if and the assertion macro header
`default_nettype none
`include "mutex_with_wake_all_queue_defines.svh"

module mwq_front #(
  parameter int TID_W = mwq_pkg::TASK_ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mwq_req_if.sink           in_ch,
  output logic              cmd_valid,
  output mwq_pkg::mwq_op_t  cmd_op,
  output logic [TID_W-1:0]  cmd_tid,
  input  logic              cmd_pop
);
  import mwq_pkg::*;

  mwq_op_t          ent_op_r  [CQ_DEPTH];
  logic [TID_W-1:0] ent_tid_r [CQ_DEPTH];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;
  mwq_op_t          dec_op;

  always_comb begin
    dec_op = '0;
    unique case (in_ch.mode)
      MODE_ATTEMPT: dec_op.is_try    = 1'b1;
      MODE_LOCK:    dec_op.is_lock   = 1'b1;
      MODE_UNLOCK:  dec_op.is_unlock = 1'b1;
      MODE_INIT:    dec_op.is_init   = 1'b1;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'(CQ_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = cmd_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_op_r[wptr_r]  <= dec_op;
      ent_tid_r[wptr_r] <= in_ch.task_id;
    end
  end

  assign cmd_valid = (cnt_r != '0);
  assign cmd_op    = ent_op_r[rptr_r];
  assign cmd_tid   = ent_tid_r[rptr_r];

  `MWQ_ASSERT_IMP(a_cq_bound, 1'b1, cnt_r <= 2'(CQ_DEPTH))
  `MWQ_ASSERT_IMP(a_pop_nonempty, cmd_pop, cnt_r != '0)
  `MWQ_ASSERT_NXT(a_push_count, push && !cmd_pop, cnt_r == $past(cnt_r) + 2'd1)

endmodule

`default_nettype wire

// ===== src/mwq_back.sv =====
// back: owner state, wait queue and result register; drains waiters on unlock
// depends on mwq_pkg, mwq_rsp_if, mwq_ram and the assertion macro header
`default_nettype none
`include "mutex_with_wake_all_queue_defines.svh"

module mwq_back #(
  parameter int WAIT_DEPTH = mwq_pkg::WAIT_DEPTH_DEF,
  parameter int TID_W      = mwq_pkg::TASK_ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  mwq_pkg::mwq_op_t  cmd_op,
  input  logic [TID_W-1:0]  cmd_tid,
  output logic              cmd_pop,
  mwq_rsp_if.source         out_ch
);
  import mwq_pkg::*;

  localparam int IDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic             st_r, st_nxt;
  logic             own_v_r, own_v_nxt;
  logic [TID_W-1:0] own_id_r, own_id_nxt;
  // head stays at zero: the queue only empties as a whole
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] rptr_r, rptr_nxt;

  logic             ov_r, ov_nxt;
  logic             o_kind_r, o_kind_nxt;
  logic             o_ok_r, o_ok_nxt;
  logic             o_full_r, o_full_nxt;
  logic             o_own_v_r, o_own_v_nxt;
  logic [TID_W-1:0] o_own_r, o_own_nxt;
  logic             o_holds_r, o_holds_nxt;
  logic [TID_W-1:0] o_rel_r, o_rel_nxt;
  logic             o_last_r, o_last_nxt;

  logic             slot_free;
  logic             grant;
  logic             we;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic [TID_W-1:0] rdata;

  mwq_ram #(
    .DATA_W (TID_W),
    .DEPTH  (WAIT_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (we),
    .waddr (tail_r),
    .wdata (cmd_tid),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign slot_free = !ov_r || out_ch.ready;
  assign grant     = !own_v_r || (own_id_r == cmd_tid);

  always_comb begin
    st_nxt      = st_r;
    own_v_nxt   = own_v_r;
    own_id_nxt  = own_id_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    rptr_nxt    = rptr_r;
    ov_nxt      = ov_r && !out_ch.ready;
    o_kind_nxt  = o_kind_r;
    o_ok_nxt    = o_ok_r;
    o_full_nxt  = o_full_r;
    o_own_v_nxt = o_own_v_r;
    o_own_nxt   = o_own_r;
    o_holds_nxt = o_holds_r;
    o_rel_nxt   = o_rel_r;
    o_last_nxt  = o_last_r;
    cmd_pop     = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = rptr_r;

    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_pop    = 1'b1;
          ov_nxt     = 1'b1;
          o_kind_nxt = KIND_STATUS;
          o_ok_nxt   = 1'b0;
          o_full_nxt = 1'b0;
          o_rel_nxt  = '0;
          o_last_nxt = 1'b1;
          if (cmd_op.is_try || cmd_op.is_lock) begin
            if (grant) begin
              own_v_nxt  = 1'b1;
              own_id_nxt = cmd_tid;
              o_ok_nxt   = 1'b1;
            end else if (cmd_op.is_lock) begin
              if (cnt_r == CNT_W'(WAIT_DEPTH)) begin
                o_full_nxt = 1'b1;
              end else begin
                we       = 1'b1;
                tail_nxt = (tail_r == IDX_W'(WAIT_DEPTH - 1)) ? '0 : tail_r + IDX_W'(1);
                cnt_nxt  = cnt_r + CNT_W'(1);
              end
            end
          end else if (cmd_op.is_unlock) begin
            if (grant) begin
              own_v_nxt  = 1'b0;
              own_id_nxt = '0;
              o_ok_nxt   = 1'b1;
              tail_nxt   = '0;
              cnt_nxt    = '0;
              if (cnt_r != '0) begin
                // fetch the first waiter while the status goes out
                o_last_nxt = 1'b0;
                st_nxt     = ST_DRAIN;
                rem_nxt    = cnt_r;
                rptr_nxt   = '0;
                re         = 1'b1;
                raddr      = '0;
              end
            end
          end else if (cmd_op.is_init) begin
            own_v_nxt  = 1'b0;
            own_id_nxt = '0;
            tail_nxt   = '0;
            cnt_nxt    = '0;
            o_ok_nxt   = 1'b1;
          end
          o_own_v_nxt = own_v_nxt;
          o_own_nxt   = own_id_nxt;
          o_holds_nxt = own_v_nxt && (own_id_nxt == cmd_tid);
        end
      end
      ST_DRAIN: begin
        if (slot_free) begin
          ov_nxt      = 1'b1;
          o_kind_nxt  = KIND_RELEASE;
          o_ok_nxt    = 1'b1;
          o_full_nxt  = 1'b0;
          o_own_v_nxt = 1'b0;
          o_own_nxt   = '0;
          o_holds_nxt = 1'b0;
          o_rel_nxt   = rdata;
          o_last_nxt  = (rem_r == CNT_W'(1));
          rem_nxt     = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            st_nxt = ST_IDLE;
          end else begin
            re       = 1'b1;
            raddr    = rptr_r + IDX_W'(1);
            rptr_nxt = rptr_r + IDX_W'(1);
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      own_v_r  <= 1'b0;
      own_id_r <= '0;
      tail_r   <= '0;
      cnt_r    <= '0;
      rem_r    <= '0;
      rptr_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      own_v_r  <= own_v_nxt;
      own_id_r <= own_id_nxt;
      tail_r   <= tail_nxt;
      cnt_r    <= cnt_nxt;
      rem_r    <= rem_nxt;
      rptr_r   <= rptr_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_kind_r  <= o_kind_nxt;
    o_ok_r    <= o_ok_nxt;
    o_full_r  <= o_full_nxt;
    o_own_v_r <= o_own_v_nxt;
    o_own_r   <= o_own_nxt;
    o_holds_r <= o_holds_nxt;
    o_rel_r   <= o_rel_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.kind            = o_kind_r;
  assign out_ch.success         = o_ok_r;
  assign out_ch.queue_full      = o_full_r;
  assign out_ch.owner_valid     = o_own_v_r;
  assign out_ch.owner_task      = o_own_r;
  assign out_ch.requester_holds = o_holds_r;
  assign out_ch.released_task   = o_rel_r;
  assign out_ch.last            = o_last_r;

  `MWQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(WAIT_DEPTH))
  `MWQ_ASSERT_IMP(a_no_pop_drain, st_r == ST_DRAIN, !cmd_pop)
  `MWQ_ASSERT_IMP(a_drain_rem, st_r == ST_DRAIN, rem_r != '0)
  `MWQ_ASSERT_IMP(a_owner_clear, !own_v_r, own_id_r == '0)
  `MWQ_ASSERT_NXT(a_drain_start, cmd_pop && cmd_op.is_unlock && grant && cnt_r != '0,
                  st_r == ST_DRAIN && ov_r && !o_last_r)

endmodule

`default_nettype wire

// ===== src/mutex_with_wake_all_queue.sv =====
// top level of the mutex with wake-all wait queue
// depends on mwq_pkg, mwq_req_if, mwq_rsp_if, mwq_front and mwq_back
//
//  channel | dir | handshake             | payload
//  in_ch   | in  | valid/ready, transfer | mode, task_id
//  out_ch  | out | valid/ready, transfer | kind, success, queue_full, owner_valid,
//          |     |                       | owner_task, requester_holds, released_task, last
//
// attempt, lock and init leave the back part free for the next request, one request per cycle
// sustained unless out_ch stalls; a status passes the front queue, then the result register
// an unlock that releases n waiters sends a status and then n releases: the back part reads
// one wait ram entry per cycle unless out_ch stalls, and takes no request meanwhile
// synchronous reset clears owner, queue count and command queue; no clearing pass
// an out_ch stall holds the back part; the front queue still takes two requests
`default_nettype none

module mutex_with_wake_all_queue #(
  parameter int WAIT_DEPTH   = mwq_pkg::WAIT_DEPTH_DEF,
  parameter int TASK_ID_BITS = mwq_pkg::TASK_ID_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mwq_req_if.sink    in_ch,
  mwq_rsp_if.source  out_ch
);
  import mwq_pkg::*;

  logic                    cmd_valid;
  mwq_op_t                 cmd_op;
  logic [TASK_ID_BITS-1:0] cmd_tid;
  logic                    cmd_pop;

  mwq_front #(
    .TID_W (TASK_ID_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_op    (cmd_op),
    .cmd_tid   (cmd_tid),
    .cmd_pop   (cmd_pop)
  );

  mwq_back #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .TID_W      (TASK_ID_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_op    (cmd_op),
    .cmd_tid   (cmd_tid),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== sim/mutex_with_wake_all_queue_tb.sv =====
`timescale 1ns / 100ps
// testbench of mutex_with_wake_all_queue: directed and random attempt, lock, unlock
// and init requests, each result checked against a behavioral copy of owner and wait queue
// depends on mwq_pkg, mwq_req_if, mwq_rsp_if and the rtl of the block

module mutex_with_wake_all_queue_tb;
  import mwq_pkg::*;

  localparam int TID_W  = TASK_ID_BITS_DEF;
  localparam int QDEPTH = WAIT_DEPTH_DEF;

  typedef struct packed {
    logic             kind;
    logic             success;
    logic             queue_full;
    logic             owner_valid;
    logic [TID_W-1:0] owner_task;
    logic             requester_holds;
    logic [TID_W-1:0] released_task;
    logic             last;
  } mutex_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mwq_req_if #(.TID_W(TID_W)) in_ch ();
  mwq_rsp_if #(.TID_W(TID_W)) out_ch ();

  mutex_with_wake_all_queue #(
    .WAIT_DEPTH  (QDEPTH),
    .TASK_ID_BITS(TID_W)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioral copy of the mutex
  logic             holder_valid;
  logic [TID_W-1:0] holder_id;
  logic [TID_W-1:0] waiter_ids[$];

  mutex_result_t    pending_results[$];
  logic [TID_W-1:0] id_pool[6];

  int error_count    = 0;
  int items_sent     = 0;
  int rx_hold_cycles = 0;
  bit src_idle_en    = 1'b0;
  bit sink_idle_en   = 1'b0;

  function automatic string fmt_result(input mutex_result_t r);
    return $sformatf("kind=%0d ok=%0d full=%0d ov=%0d owner=%02h holds=%0d rel=%02h last=%0d",
                     r.kind, r.success, r.queue_full, r.owner_valid, r.owner_task,
                     r.requester_holds, r.released_task, r.last);
  endfunction

  function automatic void report_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t ERROR %s", $realtime, msg);
  endfunction

  // applies one request to the copy and queues the status and any releases
  function automatic void predict_request(input logic [1:0] mode, input logic [TID_W-1:0] tid);
    logic             grant;
    logic             ok;
    logic             full;
    logic [TID_W-1:0] woken[$];
    mutex_result_t    r;
    grant = !holder_valid || holder_id == tid;
    ok    = 1'b0;
    full  = 1'b0;
    case (mode) inside
      MODE_ATTEMPT, MODE_LOCK: begin
        if (grant) begin
          holder_valid = 1'b1;
          holder_id    = tid;
          ok           = 1'b1;
        end else if (mode == MODE_LOCK) begin
          if (waiter_ids.size() >= QDEPTH) full = 1'b1;
          else waiter_ids.push_back(tid);
        end
      end
      MODE_UNLOCK: begin
        if (grant) begin
          holder_valid = 1'b0;
          holder_id    = '0;
          ok           = 1'b1;
          woken        = waiter_ids;
          waiter_ids.delete();
        end
      end
      default: begin
        // init drops waiters without release
        holder_valid = 1'b0;
        holder_id    = '0;
        waiter_ids.delete();
        ok           = 1'b1;
      end
    endcase
    r                 = '0;
    r.kind            = KIND_STATUS;
    r.success         = ok;
    r.queue_full      = full;
    r.owner_valid     = holder_valid;
    r.owner_task      = holder_valid ? holder_id : '0;
    r.requester_holds = holder_valid && holder_id == tid;
    r.last            = woken.size() == 0;
    pending_results.push_back(r);
    foreach (woken[i]) begin
      r               = '0;
      r.kind          = KIND_RELEASE;
      r.success       = 1'b1;
      r.released_task = woken[i];
      r.last          = i == woken.size() - 1;
      pending_results.push_back(r);
    end
  endfunction

  // called at a clock edge; returns at the edge of the transfer or after a gap
  task automatic send_request(input logic [1:0] mode, input logic [TID_W-1:0] tid);
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= mode;
    in_ch.task_id <= tid;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_request(mode, tid);
    items_sent++;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    int               r;
    logic [1:0]       mode;
    logic [TID_W-1:0] tid;
    r   = $urandom_range(0, 99);
    tid = id_pool[$urandom_range(0, 5)];
    if (r < 18) mode = MODE_ATTEMPT;
    else if (r < 58) mode = MODE_LOCK;
    else if (r < 86) begin
      mode = MODE_UNLOCK;
      if (holder_valid && $urandom_range(0, 3) != 0) tid = holder_id;
    end else if (r < 91) mode = MODE_INIT;
    else begin
      mode = 2'($urandom);
      tid  = TID_W'($urandom);
    end
    send_request(mode, tid);
  endtask

  // owner takes the lock, then enough contenders to overflow the wait queue
  task automatic fill_wait_queue();
    send_request(MODE_LOCK, id_pool[0]);
    repeat (QDEPTH + 1) send_request(MODE_LOCK, TID_W'($urandom));
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_unlock_when_free();
    send_request(MODE_UNLOCK, 8'h55);
  endtask

  task automatic test_ownership();
    send_request(MODE_ATTEMPT, 8'h00);
    send_request(MODE_ATTEMPT, 8'h00);
    send_request(MODE_ATTEMPT, 8'hFF);
    send_request(MODE_LOCK, 8'h00);
    send_request(MODE_UNLOCK, 8'hAA);
  endtask

  // owner 00 holds; the last two waiters are the same task
  task automatic test_queue_full();
    for (int i = 0; i < QDEPTH; i++) begin
      send_request(MODE_LOCK, (i < QDEPTH - 2) ? TID_W'(i * 16 + 3) : 8'hFF);
    end
    send_request(MODE_LOCK, 8'hAA);
    send_request(MODE_UNLOCK, 8'h00);
  endtask

  task automatic test_init_drops_waiters();
    send_request(MODE_LOCK, 8'h12);
    send_request(MODE_LOCK, 8'h34);
    send_request(MODE_LOCK, 8'h55);
    send_request(MODE_INIT, 8'h34);
    send_request(MODE_UNLOCK, 8'h55);
  endtask

  task automatic test_receiver_hold();
    rx_hold_cycles = 150;
    src_idle_en    = 1'b0;
    repeat (24) send_random_item();
    src_idle_en    = 1'b1;
  endtask

  task automatic test_sender_pause();
    fill_wait_queue();
    wait_results_drained();
    send_request(MODE_UNLOCK, holder_id);
  endtask

  task automatic test_random(input int item_target);
    while (items_sent < item_target) begin
      if ($urandom_range(0, 29) == 0) fill_wait_queue();
      else send_random_item();
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
        out_ch.ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= rst_n;
      end
    end
  end

  // check every result transfer against the oldest expectation
  always @(posedge clk) begin
    mutex_result_t got;
    mutex_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind            = out_ch.kind;
      got.success         = out_ch.success;
      got.queue_full      = out_ch.queue_full;
      got.owner_valid     = out_ch.owner_valid;
      got.owner_task      = out_ch.owner_task;
      got.requester_holds = out_ch.requester_holds;
      got.released_task   = out_ch.released_task;
      got.last            = out_ch.last;
      if (pending_results.size() == 0) begin
        report_error({"unexpected result ", fmt_result(got)});
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          report_error({"result mismatch: expected ", fmt_result(want),
                        " got ", fmt_result(got)});
        end
      end
    end
  end

  initial begin
    int waited;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_ATTEMPT;
    in_ch.task_id <= '0;
    holder_valid  = 1'b0;
    holder_id     = '0;
    foreach (id_pool[i]) id_pool[i] = TID_W'($urandom);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    test_unlock_when_free();
    test_ownership();
    test_queue_full();
    test_init_drops_waiters();
    test_receiver_hold();
    test_sender_pause();
    test_random(250);
    // closing stretch at full rate on both sides
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random(280);

    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_error($sformatf("%0d expected results never arrived", pending_results.size()));
    end
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
